// ----- sv/c3c_pkg.sv -----
// ----------------------------------------------------------------------------
// c3c_pkg: shared types and constants for the 3x3 RGB convolution block
// Register codes, field widths, pipeline control and result beat types.
// ----------------------------------------------------------------------------
package c3c_pkg;

    // sizing defaults for the top-level parameters
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // field widths
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int COEF_W       = 8;
    localparam int KERNEL_W     = 3 * COEF_W;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;

    // arithmetic widths: tap product, row of three, full window of nine
    localparam int PROD_W   = COEF_W + CH_W + 1;
    localparam int ROWSUM_W = PROD_W + 2;
    localparam int SUM_W    = ROWSUM_W + 2;

    // output queue
    localparam int FIFO_DEPTH = 8;

    // register reset values
    localparam logic [CH_W-1:0]         MAX_VALUE_RESET = 8'd255;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = 13'd1024;

    // register index codes
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;

    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ROWSUM_W-1:0] rowsum_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // per-item control carried down the pipeline; valid means a result is due
    typedef struct packed {
        logic valid;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } tap_ctl_t;

    typedef struct packed {
        logic            frame_last;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } out_beat_t;

endpackage

// ----- sv/c3c_ram.sv -----
// ----------------------------------------------------------------------------
// c3c_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module c3c_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/c3c_tap_cell.sv -----
// ----------------------------------------------------------------------------
// c3c_tap_cell: one window cell of the 3x3 convolution
// Holds one RGB sample, hands it to its left neighbor on shift, and
// registers coefficient times sample for each channel.
// ----------------------------------------------------------------------------
module c3c_tap_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift,
    input  logic [c3c_pkg::PIX_W-1:0] pix_in,
    output logic [c3c_pkg::PIX_W-1:0] pix_out,
    input  logic signed [c3c_pkg::COEF_W-1:0] coef,
    input  logic                      tap_en,
    output c3c_pkg::prod_t            prod [3]
);

    import c3c_pkg::*;

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;
    prod_t            prod_reg  [3];
    prod_t            prod_next [3];

    assign pix_next = shift ? pix_in : pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else
        begin
            pix_reg <= pix_next;
        end
    end

    // 8-bit signed coefficient times 9-bit zero-extended sample
    always_comb
    begin
        logic signed [CH_W:0] sample;
        for (int ch = 0; ch < 3; ch++)
        begin
            sample = $signed({1'b0, pix_reg[CH_W*ch +: CH_W]});
            prod_next[ch] = tap_en ? prod_t'(coef * sample) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

// ----- sv/c3c_sum_clamp.sv -----
// ----------------------------------------------------------------------------
// c3c_sum_clamp: adder tree and clamp for the 3x3 convolution
// Registers the three row sums per channel, then adds and clamps to
// 0..max_value.
// ----------------------------------------------------------------------------
module c3c_sum_clamp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  c3c_pkg::prod_t           prod [3][3][3],
    input  c3c_pkg::tap_ctl_t        ctl_in,
    input  logic [c3c_pkg::CH_W-1:0] max_value,
    output logic                     res_valid,
    output c3c_pkg::out_beat_t       res
);

    import c3c_pkg::*;

    rowsum_t row_reg  [3][3];
    rowsum_t row_next [3][3];
    logic    valid_reg;
    logic    last_reg;
    logic [CH_W-1:0] chan [3];

    // row sums, indexed [row][channel]
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                row_next[r][ch] = rowsum_t'(prod[r][0][ch]) + rowsum_t'(prod[r][1][ch])
                                + rowsum_t'(prod[r][2][ch]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        last_reg <= ctl_in.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_comb
    begin
        sum_t total;
        sum_t ceiling;
        ceiling = $signed({{(SUM_W-CH_W){1'b0}}, max_value});
        for (int ch = 0; ch < 3; ch++)
        begin
            total = sum_t'(row_reg[0][ch]) + sum_t'(row_reg[1][ch]) + sum_t'(row_reg[2][ch]);
            if (total < 0)
            begin
                chan[ch] = '0;
            end
            else if (total > ceiling)
            begin
                chan[ch] = max_value;
            end
            else
            begin
                chan[ch] = total[CH_W-1:0];
            end
        end
    end

    assign res_valid      = valid_reg;
    assign res.red        = chan[0];
    assign res.green      = chan[1];
    assign res.blue       = chan[2];
    assign res.frame_last = last_reg;

endmodule

// ----- sv/rgb_conv3x3_clamp_top.sv -----
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp_top: streaming 3x3 convolution of an RGB raster
// Two line stores feed a 3x3 array of shifting tap cells; products go through
// a registered adder tree and clamp into a small output queue.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall   pixel_red, pixel_green, pixel_blue, is_fill
//   out      out  out_valid / out_stall out_red, out_green, out_blue, frame_last
//   cfg      in   cfg_write            cfg_index, cfg_data
//
// One pixel beat per clock while in_stall is low. A result reaches the queue
// from the beat that completes its window through line store read, window shift,
// tap products, row sums, then clamp into the queue; results lag the input
// by W + 1 beats, which the host drains with fill beats after the frame.
// in_stall rises only when the 8-entry output queue plus results in flight
// would overflow, so a stalled out side does not block input until the
// queue fills. Reset clears counters, window and queue; line stores need
// no clear since out-of-image taps are masked.
//
module rgb_conv3x3_clamp_top #(
    parameter int MAX_WIDTH  = c3c_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3c_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [c3c_pkg::CH_W-1:0]        pixel_red,
    input  logic [c3c_pkg::CH_W-1:0]        pixel_green,
    input  logic [c3c_pkg::CH_W-1:0]        pixel_blue,
    input  logic                            is_fill,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [c3c_pkg::CH_W-1:0]        out_red,
    output logic [c3c_pkg::CH_W-1:0]        out_green,
    output logic [c3c_pkg::CH_W-1:0]        out_blue,
    output logic                            frame_last,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [c3c_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [c3c_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import c3c_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W  = $clog2(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KERNEL_W-1:0]     kern_reg [3];
    logic [CH_W-1:0]         max_value_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    size_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern_reg[0]   <= '0;
            kern_reg[1]   <= '0;
            kern_reg[2]   <= '0;
            max_value_reg <= MAX_VALUE_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KERNEL_TOP:    kern_reg[0]   <= cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_MIDDLE: kern_reg[1]   <= cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_BOTTOM: kern_reg[2]   <= cfg_data[KERNEL_W-1:0];
                CFG_MAX_VALUE:     max_value_reg <= cfg_data[CH_W-1:0];
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_data[HEIGHT_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // a size write restarts the frame
    assign size_write = cfg_write
                     && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    // effective sizes: zero counts as one, oversize counts as the maximum
    logic [WCNT_W-1:0] w_eff;
    logic [HCNT_W-1:0] h_eff;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WCNT_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCNT_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = HCNT_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HCNT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HCNT_W'(height_reg);
        end
    end

    assign w_last = COL_W'(w_eff - WCNT_W'(1));
    assign h_last = ROW_W'(h_eff - HCNT_W'(1));

    // ------------------------------------------------------------------
    // Input side: raster counters and result bookkeeping
    // ------------------------------------------------------------------
    logic              in_beat;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              fifo_push;
    logic              fifo_pop;

    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [HCNT_W-1:0] in_row_reg,  in_row_next;
    logic              armed_reg,   armed_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              live;
    logic              produce;
    tap_ctl_t          ctl_new;
    logic [PIX_W-1:0]  pix_new;

    // stall only on queue room, so a result always has a slot when it lands
    assign in_stall = (pending_reg >= PEND_W'(FIFO_DEPTH));
    assign in_beat  = in_valid && !in_stall;

    assign live    = (in_row_reg < h_eff);
    assign produce = armed_reg;

    // window position of the result this beat completes
    always_comb
    begin
        ctl_new.valid  = in_beat && produce;
        ctl_new.top    = (out_row_reg == '0);
        ctl_new.bottom = (out_row_reg == h_last);
        ctl_new.left   = (out_col_reg == '0);
        ctl_new.right  = (out_col_reg == w_last);
        ctl_new.last   = ctl_new.bottom && ctl_new.right;
    end

    // beats past the frame end, and fill beats, carry a zero pixel
    assign pix_new = (!is_fill && live) ? {pixel_blue, pixel_green, pixel_red} : '0;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        armed_next   = armed_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (size_write || (in_beat && produce && ctl_new.last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            armed_next   = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (in_beat)
        begin
            // results start once W + 1 beats of the frame have gone in
            armed_next = armed_reg || (in_row_reg != '0);
            if (in_col_reg == w_last)
            begin
                in_col_next = '0;
                if (live)
                begin
                    in_row_next = in_row_reg + HCNT_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (produce)
            begin
                if (out_col_reg == w_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (ctl_new.valid && !fifo_pop)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (!ctl_new.valid && fifo_pop)
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            armed_reg   <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            armed_reg   <= armed_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0 -> 1: line store read, write-back and window shift
    // ------------------------------------------------------------------
    logic             shift0_reg;
    logic [COL_W-1:0] col0_reg;
    logic [PIX_W-1:0] pix0_reg;
    tap_ctl_t         ctl0_reg;
    tap_ctl_t         ctl1_reg;
    tap_ctl_t         ctl2_reg;

    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] lower_rd;
    logic [PIX_W-1:0] top_eff;
    logic [PIX_W-1:0] mid_eff;

    // read/write collision bypass (same column on consecutive beats: W of 1)
    logic             fwd_reg;
    logic             fwd_next;
    logic [PIX_W-1:0] fwd_upper_reg;
    logic [PIX_W-1:0] fwd_lower_reg;

    assign fwd_next = in_beat && shift0_reg && (in_col_reg == col0_reg);
    assign top_eff  = fwd_reg ? fwd_upper_reg : upper_rd;
    assign mid_eff  = fwd_reg ? fwd_lower_reg : lower_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift0_reg <= 1'b0;
            ctl0_reg   <= '0;
            ctl1_reg   <= '0;
            ctl2_reg   <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            shift0_reg <= in_beat;
            ctl0_reg   <= ctl_new;
            ctl1_reg   <= ctl0_reg;
            ctl2_reg   <= ctl1_reg;
            fwd_reg    <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            col0_reg      <= in_col_reg;
            pix0_reg      <= pix_new;
            fwd_upper_reg <= mid_eff;
            fwd_lower_reg <= pix0_reg;
        end
    end

    // upper store takes the old lower row, lower store takes the new pixel
    c3c_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk     (clk),
        .wr_en   (shift0_reg),
        .wr_addr (col0_reg),
        .wr_data (mid_eff),
        .rd_en   (in_beat),
        .rd_addr (in_col_reg),
        .rd_data (upper_rd)
    );

    c3c_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_lower (
        .clk     (clk),
        .wr_en   (shift0_reg),
        .wr_addr (col0_reg),
        .wr_data (pix0_reg),
        .rd_en   (in_beat),
        .rd_addr (in_col_reg),
        .rd_data (lower_rd)
    );

    // ------------------------------------------------------------------
    // 3x3 cell array: rows fed by top, mid and new pixel at the right end
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] row_in   [3];
    logic [PIX_W-1:0] cell_pix [3][3];
    prod_t            cell_prod [3][3][3];

    assign row_in[0] = top_eff;
    assign row_in[1] = mid_eff;
    assign row_in[2] = pix0_reg;

    for (genvar rr = 0; rr < 3; rr++)
    begin : g_row
        for (genvar cc = 0; cc < 3; cc++)
        begin : g_col
            logic [PIX_W-1:0] feed;
            logic             tap_en;

            if (cc == 2)
            begin : g_edge
                assign feed = row_in[rr];
            end
            else
            begin : g_inner
                assign feed = cell_pix[rr][cc+1];
            end

            // taps that fall outside the image are zeroed
            assign tap_en = !((rr == 0) && ctl1_reg.top) && !((rr == 2) && ctl1_reg.bottom)
                         && !((cc == 0) && ctl1_reg.left) && !((cc == 2) && ctl1_reg.right);

            c3c_tap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift0_reg),
                .pix_in  (feed),
                .pix_out (cell_pix[rr][cc]),
                .coef    ($signed(kern_reg[rr][COEF_W*cc +: COEF_W])),
                .tap_en  (tap_en),
                .prod    (cell_prod[rr][cc])
            );
        end
    end

    // ------------------------------------------------------------------
    // Adder tree and clamp
    // ------------------------------------------------------------------
    out_beat_t res;

    c3c_sum_clamp u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod      (cell_prod),
        .ctl_in    (ctl2_reg),
        .max_value (max_value_reg),
        .res_valid (fifo_push),
        .res       (res)
    );

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    out_beat_t         fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PEND_W-1:0] fifo_count_reg, fifo_count_next;
    out_beat_t         head;

    assign out_valid = (fifo_count_reg != '0);
    assign fifo_pop  = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fifo_count_next = fifo_count_reg;
        if (fifo_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (fifo_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (fifo_push && !fifo_pop)
        begin
            fifo_count_next = fifo_count_reg + PEND_W'(1);
        end
        else if (!fifo_push && fifo_pop)
        begin
            fifo_count_next = fifo_count_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign head       = fifo_mem_reg[rd_ptr_reg];
    assign out_red    = head.red;
    assign out_green  = head.green;
    assign out_blue   = head.blue;
    assign frame_last = head.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // queue room was reserved at input, so a push never meets a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count_reg < PEND_W'(FIFO_DEPTH)))
        else $error("output queue overflow");

    // reservation count covers everything already queued
    a_pending_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg >= fifo_count_reg)
        else $error("pending count below queue fill");

    // a result in the tap stage is counted beyond what sits in the queue
    a_inflight_counted: assert property (@(posedge clk) disable iff (!rst_n)
        ctl2_reg.valid |-> (pending_reg > fifo_count_reg))
        else $error("result in flight not reserved");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgb_conv3x3_clamp_top
// Streams RGB frames through the 3x3 convolution block and checks every result
// beat against an in-bench convolution predictor. A short table of directed
// frames comes first, then the widest and tallest frames, then random phases
// with sender idling, receiver stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    import c3c_pkg::*;

    localparam int MAX_W        = DEFAULT_MAX_WIDTH;
    localparam int MAX_H        = DEFAULT_MAX_HEIGHT;
    localparam int SETTLE_CYC   = 12;      // pipeline depth plus margin
    localparam int HOLD_CYCLES  = 300;     // long output hold-off
    localparam int PHASE_BEATS  = 110;     // fewest input beats per random phase
    localparam int CYCLE_LIMIT  = 300000;

    // register indexes the block does not decode; writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    // register write masks, one bit per register index
    localparam logic [5:0] WR_ALL  = 6'h3F;
    localparam logic [5:0] WR_SIZE = (6'b1 << CFG_IMAGE_WIDTH) | (6'b1 << CFG_IMAGE_HEIGHT);
    localparam logic [5:0] WR_CLAMP_SIZE = WR_SIZE | (6'b1 << CFG_MAX_VALUE);

    typedef enum logic [1:0] {
        PAT_CONST,      // every pixel the same
        PAT_RANDOM,     // random pixels
        PAT_HOLES       // odd beats are fills inside the frame, drain beats carry pixels
    } pix_pattern_e;

    // one directed frame: register writes, pixel pattern, optional fixed result
    typedef struct packed {
        logic [5:0]   wr_mask;
        bit           spare;
        logic [23:0]  kt;
        logic [23:0]  km;
        logic [23:0]  kb;
        logic [23:0]  mx;
        logic [23:0]  wd;
        logic [23:0]  hd;
        pix_pattern_e pattern;
        logic [23:0]  pix;      // {blue, green, red}
        bit           known;
        logic [23:0]  want;     // {blue, green, red} of every result
    } frame_case_t;

    localparam int NUM_CASES = 7;

    frame_case_t frame_cases [NUM_CASES] = '{
        // kernels still at reset (all zero): everything filters to 0
        '{WR_SIZE, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h1, 24'h2,
          PAT_CONST, 24'hFFFFFF, 1'b1, 24'h000000},
        // center tap only, zero width and height count as one
        '{WR_ALL, 1'b0, 24'h0, 24'h000100, 24'h0, 24'h0000FF, 24'h0, 24'h0,
          PAT_CONST, 24'h80FF00, 1'b1, 24'h80FF00},
        // ceiling 100 from masked data: 99 passes, 100 is kept, 255 clamps
        '{WR_CLAMP_SIZE, 1'b0, 24'h0, 24'h0, 24'h0, 24'hABCD64, 24'hFFF801, 24'hFFE001,
          PAT_CONST, 24'h64FF63, 1'b1, 24'h646463},
        // negative center tap: sums below zero give 0
        '{WR_ALL, 1'b0, 24'h0, 24'h00FF00, 24'h0, 24'h0000FF, 24'h2, 24'h1,
          PAT_CONST, 24'h123456, 1'b1, 24'h000000},
        // largest positive coefficients on full-scale pixels clamp high
        '{WR_ALL, 1'b0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'h0000FF, 24'h1, 24'h2,
          PAT_CONST, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        // most negative coefficients, plus writes to undecoded indexes
        '{WR_ALL, 1'b1, 24'h808080, 24'h808080, 24'h808080, 24'h0000FF, 24'h2, 24'h1,
          PAT_CONST, 24'hFFFFFF, 1'b1, 24'h000000},
        // mixed kernel, fills inside the frame, pixel beats during the drain
        '{WR_ALL, 1'b0, 24'h01FE01, 24'h02FF03, 24'hFF0100, 24'h0000C8, 24'h3, 24'h2,
          PAT_HOLES, 24'h0, 1'b0, 24'h0}
    };

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CH_W-1:0]   pixel_red;
    logic [CH_W-1:0]   pixel_green;
    logic [CH_W-1:0]   pixel_blue;
    logic              is_fill;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
    logic              frame_last;
    logic              cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb_conv3x3_clamp_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .is_fill     (is_fill),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .frame_last  (frame_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // convolution predictor: its own copy of registers, line stores and window
    // ------------------------------------------------------------------------
    logic [KERNEL_W-1:0]     conv_kt, conv_km, conv_kb;
    logic [CH_W-1:0]         conv_ceiling;
    logic [WIDTH_REG_W-1:0]  conv_width;
    logic [HEIGHT_REG_W-1:0] conv_height;
    logic [PIX_W-1:0]        conv_line_up [MAX_W];
    logic [PIX_W-1:0]        conv_line_lo [MAX_W];
    logic [PIX_W-1:0]        conv_win [9];    // row-major, index 2/5/8 newest column
    int unsigned             conv_col;
    int unsigned             conv_row;
    longint                  conv_out_idx;

    out_beat_t expected_pixels [$];   // results still owed by the block

    int  mismatches = 0;
    int  beats_accepted = 0;
    int  snd_idle_pct = 0;
    int  rcv_stall_pct = 0;
    int  hold_kick = 0;
    int  hold_taken = 0;
    int  hold_left = 0;
    int  cycle_count = 0;

    // zero means one; anything past maxv means maxv
    function automatic int unsigned size_limit(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int tap_coef(input logic [KERNEL_W-1:0] row_reg, input int pos);
        return int'($signed(row_reg[8*pos +: 8]));
    endfunction

    task automatic conv_restart();
        conv_col = 0;
        conv_row = 0;
        conv_out_idx = 0;
    endtask

    task automatic conv_reset();
        conv_kt = '0;
        conv_km = '0;
        conv_kb = '0;
        conv_ceiling = MAX_VALUE_RESET;
        conv_width = WIDTH_RESET;
        conv_height = HEIGHT_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            conv_line_up[i] = '0;
            conv_line_lo[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            conv_win[i] = '0;
        conv_restart();
    endtask

    task automatic conv_cfg_apply(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KERNEL_TOP:    conv_kt = data[KERNEL_W-1:0];
            CFG_KERNEL_MIDDLE: conv_km = data[KERNEL_W-1:0];
            CFG_KERNEL_BOTTOM: conv_kb = data[KERNEL_W-1:0];
            CFG_MAX_VALUE:     conv_ceiling = data[CH_W-1:0];
            CFG_IMAGE_WIDTH:
            begin
                conv_width = data[WIDTH_REG_W-1:0];
                conv_restart();
            end
            CFG_IMAGE_HEIGHT:
            begin
                conv_height = data[HEIGHT_REG_W-1:0];
                conv_restart();
            end
            default: ;
        endcase
    endtask

    // advance the predictor by one accepted input beat
    task automatic conv_step(input logic [PIX_W-1:0] pix_in, input logic fill,
                             output bit produced, output out_beat_t beat);
        int unsigned w, h, col;
        longint total, s, o, r, c;
        logic [PIX_W-1:0] pix, top, mid;
        logic [KERNEL_W-1:0] krow;
        int sum;
        bit last;

        w = size_limit(conv_width, MAX_W);
        h = size_limit(conv_height, MAX_H);
        total = longint'(w) * longint'(h);
        s = longint'(conv_row) * longint'(w) + longint'(conv_col);
        // fills and anything past the frame's last pixel enter as zero
        pix = (!fill && s < total) ? pix_in : '0;
        col = conv_col % MAX_W;

        top = conv_line_up[col];
        mid = conv_line_lo[col];
        conv_line_up[col] = mid;
        conv_line_lo[col] = pix;

        for (int i = 0; i < 3; i++)
        begin
            conv_win[i*3]     = conv_win[i*3 + 1];
            conv_win[i*3 + 1] = conv_win[i*3 + 2];
        end
        conv_win[2] = top;
        conv_win[5] = mid;
        conv_win[8] = pix;

        conv_col++;
        if (conv_col >= w)
        begin
            conv_col = 0;
            conv_row++;
        end

        produced = 1'b0;
        beat = '0;
        if (s < longint'(w) + 1)
            return;

        o = conv_out_idx;
        r = o / w;
        c = o % w;
        last = (o + 1 >= total);
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int rr = 0; rr < 3; rr++)
            begin
                // taps outside the image are masked
                if (rr == 0 && r == 0)
                    continue;
                if (rr == 2 && r + 1 >= h)
                    continue;
                krow = (rr == 0) ? conv_kt : (rr == 1) ? conv_km : conv_kb;
                for (int k = 0; k < 3; k++)
                begin
                    if (k == 0 && c == 0)
                        continue;
                    if (k == 2 && c + 1 >= w)
                        continue;
                    sum += tap_coef(krow, k) * int'(conv_win[rr*3 + k][8*ch +: 8]);
                end
            end
            if (sum < 0)
                sum = 0;
            if (sum > int'(conv_ceiling))
                sum = int'(conv_ceiling);
            case (ch)
                0: beat.red   = sum[7:0];
                1: beat.green = sum[7:0];
                default: beat.blue = sum[7:0];
            endcase
        end
        beat.frame_last = last;
        produced = 1'b1;
        conv_out_idx = o + 1;
        if (last)
            conv_restart();
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // config write; the caller lowers cfg_write after its last write
    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        conv_cfg_apply(idx, data);
    endtask

    // offer one beat, with random idle cycles first, and predict once taken
    task automatic send_beat(input logic [PIX_W-1:0] pix, input logic fill,
                             input bit known, input logic [PIX_W-1:0] want);
        bit produced;
        out_beat_t beat;

        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_red   <= pix[7:0];
        pixel_green <= pix[15:8];
        pixel_blue  <= pix[23:16];
        is_fill     <= fill;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_accepted++;
        conv_step(pix, fill, produced, beat);
        if (produced)
        begin
            if (known)
            begin
                beat.red   = want[7:0];
                beat.green = want[15:8];
                beat.blue  = want[23:16];
            end
            expected_pixels.push_back(beat);
        end
    endtask

    // one frame at the current size, pixels then W + 1 drain beats;
    // a partial frame stops at a random beat short of the end
    task automatic run_frame(input pix_pattern_e pat, input logic [PIX_W-1:0] pix_const,
                             input int fill_pct, input int drain_px_pct, input bit partial,
                             input bit known, input logic [PIX_W-1:0] want);
        int unsigned w, h, n_pix, n_all, n_send;
        logic [PIX_W-1:0] pix;
        logic fill;

        w = size_limit(conv_width, MAX_W);
        h = size_limit(conv_height, MAX_H);
        n_pix = w * h;
        n_all = n_pix + w + 1;
        n_send = partial ? $urandom_range(n_all - 1, 1) : n_all;
        for (int unsigned i = 0; i < n_send; i++)
        begin
            pix = (pat == PAT_CONST && i < n_pix) ? pix_const : PIX_W'($urandom);
            if (i < n_pix)
                fill = (pat == PAT_HOLES) ? logic'(i % 2) : ($urandom_range(99) < fill_pct);
            else
                fill = (pat == PAT_HOLES) ? 1'b0 : !($urandom_range(99) < drain_px_pct);
            send_beat(pix, fill, known, want);
        end
    endtask

    // wait until every owed result has come out, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [KERNEL_W-1:0] rand_kernel_row();
        logic [KERNEL_W-1:0] k;
        int pick, v;
        pick = $urandom_range(3);
        for (int i = 0; i < 3; i++)
        begin
            v = int'($urandom_range(6)) - 3;
            case (pick)
                0, 1: k[8*i +: 8] = v[7:0];                  // small, sums stay in range
                2:    k[8*i +: 8] = 8'($urandom);
                default:
                begin
                    case ($urandom_range(4))
                        0: k[8*i +: 8] = 8'h80;
                        1: k[8*i +: 8] = 8'h7F;
                        2: k[8*i +: 8] = 8'h00;
                        3: k[8*i +: 8] = 8'h01;
                        default: k[8*i +: 8] = 8'hFF;
                    endcase
                end
            endcase
        end
        return k;
    endfunction

    // kernels and ceiling always; size (which restarts the frame) on request.
    // Upper data bits carry junk to exercise the width masks.
    task automatic random_regs(input bit with_size);
        logic [CFG_DATA_W-1:0] d;
        int pick;

        d = CFG_DATA_W'($urandom);
        reg_write(CFG_KERNEL_TOP, {d[23:KERNEL_W], rand_kernel_row()});
        reg_write(CFG_KERNEL_MIDDLE, rand_kernel_row());
        reg_write(CFG_KERNEL_BOTTOM, rand_kernel_row());
        pick = $urandom_range(9);
        d = CFG_DATA_W'($urandom);
        if (pick == 0)
            d[7:0] = 8'd1;
        else if (pick == 1)
            d[7:0] = 8'd255;
        else if (pick < 8)
            d[7:0] = 8'($urandom_range(255, 30));
        reg_write(CFG_MAX_VALUE, d);
        if (with_size)
        begin
            pick = $urandom_range(9);
            d = CFG_DATA_W'($urandom);
            d[10:0] = (pick == 0) ? 11'd0 : (pick < 8) ? 11'($urandom_range(6, 1))
                                                       : 11'($urandom_range(16, 7));
            reg_write(CFG_IMAGE_WIDTH, d);
            d = CFG_DATA_W'($urandom);
            d[12:0] = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(5, 1));
            reg_write(CFG_IMAGE_HEIGHT, d);
        end
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls per phase, plus one long hold-off on request.
    // The hold-off counts its own cycles so the sender keeps pushing and the
    // block's output queue fills up until in_stall rises.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_kick != hold_taken)
        begin
            hold_taken <= hold_kick;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: r=%0d g=%0d b=%0d last=%0b",
                             out_red, out_green, out_blue, frame_last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_red !== want.red || out_green !== want.green ||
                    out_blue !== want.blue || frame_last !== want.frame_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: got r=%0d g=%0d b=%0d last=%0b, want r=%0d g=%0d b=%0d last=%0b",
                                 out_red, out_green, out_blue, frame_last,
                                 want.red, want.green, want.blue, want.frame_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frame_case_t fc;
        logic [CFG_DATA_W-1:0] d;
        int phase_start;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel_red   = '0;
        pixel_green = '0;
        pixel_blue  = '0;
        is_fill     = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        conv_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames from the table
        for (int i = 0; i < NUM_CASES; i++)
        begin
            fc = frame_cases[i];
            settle();
            if (fc.spare)
            begin
                reg_write(CFG_SPARE_A, 24'hFFFFFF);
                reg_write(CFG_SPARE_B, 24'hFFFFFF);
            end
            for (int idx = 0; idx < 6; idx++)
            begin
                if (fc.wr_mask[idx])
                begin
                    case (CFG_INDEX_W'(idx))
                        CFG_KERNEL_TOP:    d = fc.kt;
                        CFG_KERNEL_MIDDLE: d = fc.km;
                        CFG_KERNEL_BOTTOM: d = fc.kb;
                        CFG_MAX_VALUE:     d = fc.mx;
                        CFG_IMAGE_WIDTH:   d = fc.wd;
                        default:           d = fc.hd;
                    endcase
                    reg_write(CFG_INDEX_W'(idx), d);
                end
            end
            cfg_write <= 1'b0;
            run_frame(fc.pattern, fc.pix, 0, 0, 1'b0, fc.known, fc.want);
        end

        // widest frame (over-range width clamps to the store depth), then the
        // tallest one (over-range height clamps too), no idling
        settle();
        random_regs(1'b0);
        reg_write(CFG_IMAGE_WIDTH, 24'hFFF7FF);
        reg_write(CFG_IMAGE_HEIGHT, 24'h000001);
        cfg_write <= 1'b0;
        run_frame(PAT_RANDOM, '0, 0, 20, 1'b0, 1'b0, '0);
        settle();
        reg_write(CFG_IMAGE_WIDTH, 24'h000001);
        reg_write(CFG_IMAGE_HEIGHT, 24'hFFFFFF);
        cfg_write <= 1'b0;
        run_frame(PAT_RANDOM, '0, 5, 50, 1'b0, 1'b0, '0);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            snd_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 14 : 0;
            rcv_stall_pct <= (ph == 2) ? 56 : (ph == 3) ? 14 : 0;
            if (ph == 0 || ph == 2)
                hold_kick <= hold_kick + 1;
            random_regs(1'b1);
            phase_start = beats_accepted;
            while (beats_accepted - phase_start < PHASE_BEATS)
            begin
                if ($urandom_range(99) < 20)
                begin
                    settle();
                    random_regs($urandom_range(1));
                end
                if ($urandom_range(99) < 10)
                begin
                    // cut the frame short, then a size write restarts it
                    run_frame(PAT_RANDOM, '0, 10, 30, 1'b1, 1'b0, '0);
                    settle();
                    random_regs(1'b1);
                end
                else
                    run_frame(PAT_RANDOM, '0, ($urandom_range(99) < 15) ? 15 : 0, 30,
                              1'b0, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/c3c_pkg.sv
sv/c3c_ram.sv
sv/c3c_tap_cell.sv
sv/c3c_sum_clamp.sv
sv/rgb_conv3x3_clamp_top.sv
test/testbench.sv
